// ===== sv/cr_pkg.sv =====
// Shared definitions for the circle rasterizer.
// Holds the command opcode type and the pixel index constants; no dependencies.
`default_nettype none

package cr_pkg;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	localparam int PIX_PER_POINT = 8;
	localparam int PIX_IDX_BITS = 3;
	localparam logic [PIX_IDX_BITS-1:0] PIX_FIRST = 3'd0;
	localparam logic [PIX_IDX_BITS-1:0] PIX_LAST = 3'd7;

endpackage

`default_nettype wire

// ===== sv/cr_cmd_if.sv =====
// Command channel of the circle rasterizer: valid/ready handshake with payload.
// Standalone interface; no dependencies.
`default_nettype none

interface cr_cmd_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [COORD_BITS-1:0] radius;

	modport source (output valid, opcode, center_x, center_y, radius, input ready);
	modport sink (input valid, opcode, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

// ===== sv/cr_pix_if.sv =====
// Pixel channel of the circle rasterizer: valid/ready handshake with payload.
// Standalone interface; no dependencies.
`default_nettype none

interface cr_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS+1:0] pixel_x;
	logic signed [COORD_BITS+1:0] pixel_y;
	logic                         last_of_step;
	logic                         circle_done;

	modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done, input ready);
	modport sink (input valid, pixel_x, pixel_y, last_of_step, circle_done, output ready);
endinterface

`default_nettype wire

// ===== sv/cr_front.sv =====
// Front end: accepts commands, holds the circle state and runs the midpoint update.
// Pushes one point job per drawing command into the job queue; uses cr_pkg and cr_cmd_if.
`default_nettype none

module cr_front #(
	parameter int COORD_BITS = 12
) (
	input  wire                    clk,
	input  wire                    arst_n,
	cr_cmd_if.sink                 cmd,
	output logic                   push_valid,
	input  wire                    push_ready,
	output logic [4*COORD_BITS+2:0] push_data
);
	import cr_pkg::*;

	localparam int OFS_W = COORD_BITS + 1;
	localparam int DEC_W = COORD_BITS + 6;

	logic signed [OFS_W-1:0] ofs_x_q, ofs_y_q, ofs_x_d, ofs_y_d;
	logic signed [DEC_W-1:0] dec_q, dec_d;
	logic [COORD_BITS-1:0]   cx_q, cy_q, cx_d, cy_d;
	logic                    active_q, active_d;
	logic                    accept, is_start, stepping, done;
	logic signed [DEC_W-1:0] x_ext, y_ext, r_ext;

	assign cmd.ready = push_ready;
	assign accept = cmd.valid && cmd.ready;
	assign is_start = (op_t'(cmd.opcode) == OP_START);
	assign stepping = active_q && !(ofs_y_q < ofs_x_q);

	always_comb begin
		ofs_x_d = ofs_x_q;
		ofs_y_d = ofs_y_q;
		dec_d = dec_q;
		cx_d = cx_q;
		cy_d = cy_q;
		active_d = active_q;
		done = 1'b0;
		x_ext = '0;
		y_ext = '0;
		r_ext = DEC_W'(cmd.radius);
		if (is_start) begin
			cx_d = cmd.center_x;
			cy_d = cmd.center_y;
			ofs_x_d = '0;
			ofs_y_d = OFS_W'(cmd.radius);
			dec_d = DEC_W'(3) - (r_ext <<< 1);
			active_d = 1'b1;
		end else if (stepping) begin
			ofs_x_d = ofs_x_q + OFS_W'(1);
			if (dec_q > 0) begin
				ofs_y_d = ofs_y_q - OFS_W'(1);
			end
			x_ext = DEC_W'(ofs_x_d);
			y_ext = DEC_W'(ofs_y_d);
			if (dec_q > 0) begin
				dec_d = dec_q + ((x_ext - y_ext) <<< 2) + DEC_W'(10);
			end else begin
				dec_d = dec_q + (x_ext <<< 2) + DEC_W'(6);
			end
			done = (ofs_y_d < ofs_x_d);
			if (done) begin
				active_d = 1'b0;
			end
		end
	end

	assign push_valid = accept && (is_start || stepping);
	assign push_data = {done, ofs_y_d, ofs_x_d, cy_d, cx_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q <= '0;
			ofs_y_q <= '0;
			dec_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			ofs_x_q <= ofs_x_d;
			ofs_y_q <= ofs_y_d;
			dec_q <= dec_d;
			cx_q <= cx_d;
			cy_q <= cy_d;
			active_q <= active_d;
		end
	end

	a_done_ends_circle: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_data[4*COORD_BITS+2] |=> !active_q)
		else $error("circle still active after its final step");

endmodule

`default_nettype wire

// ===== sv/cr_fifo.sv =====
// Short job queue between the front end and the pixel emitter.
// Generic width and power-of-two depth; no package dependencies.
`default_nettype none

module cr_fifo #(
	parameter int WIDTH = 51,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire  [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = PTR_W + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("job queue count exceeds its depth");

endmodule

`default_nettype wire

// ===== sv/cr_back.sv =====
// Back end: takes point jobs from the queue and emits their eight symmetric pixels.
// One pixel per cycle while the pixel port is ready, through a registered output; uses cr_pkg and cr_pix_if.
`default_nettype none

module cr_back #(
	parameter int COORD_BITS = 12
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     pop_valid,
	output logic                    pop_ready,
	input  wire  [4*COORD_BITS+2:0] pop_data,
	cr_pix_if.source                pix
);
	import cr_pkg::*;

	localparam int OFS_W = COORD_BITS + 1;
	localparam int PIX_W = COORD_BITS + 2;

	logic [COORD_BITS-1:0]   cx_q, cy_q;
	logic signed [OFS_W-1:0] x_q, y_q, a_sel, b_sel;
	logic                    done_q, busy_q, load, take;
	logic [PIX_IDX_BITS-1:0] idx_q;
	logic signed [PIX_W-1:0] a_ext, b_ext, cx_ext, cy_ext, px, py;
	logic signed [PIX_W-1:0] pixel_x_q, pixel_y_q;
	logic                    last_q, circle_done_q, valid_q;

	assign load = busy_q && (!valid_q || pix.ready);
	assign pop_ready = !busy_q || (load && idx_q == PIX_LAST);
	assign take = pop_valid && pop_ready;

	always_comb begin
		a_sel = idx_q[2] ? y_q : x_q;
		b_sel = idx_q[2] ? x_q : y_q;
		a_ext = PIX_W'(a_sel);
		b_ext = PIX_W'(b_sel);
		cx_ext = PIX_W'({1'b0, cx_q});
		cy_ext = PIX_W'({1'b0, cy_q});
		px = idx_q[0] ? cx_ext - a_ext : cx_ext + a_ext;
		py = idx_q[1] ? cy_ext - b_ext : cy_ext + b_ext;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			{done_q, y_q, x_q, cy_q, cx_q} <= pop_data;
		end
		if (load) begin
			pixel_x_q <= px;
			pixel_y_q <= py;
			last_q <= (idx_q == PIX_LAST);
			circle_done_q <= (idx_q == PIX_LAST) && done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= PIX_FIRST;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (pix.ready) begin
				valid_q <= 1'b0;
			end
			if (take) begin
				busy_q <= 1'b1;
				idx_q <= PIX_FIRST;
			end else if (load) begin
				idx_q <= idx_q + PIX_IDX_BITS'(1);
				if (idx_q == PIX_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign pix.valid = valid_q;
	assign pix.pixel_x = pixel_x_q;
	assign pix.pixel_y = pixel_y_q;
	assign pix.last_of_step = last_q;
	assign pix.circle_done = circle_done_q;

	a_idx_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != PIX_FIRST |-> busy_q)
		else $error("pixel index advanced without a job in hand");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && circle_done_q |-> last_q)
		else $error("circle done flagged on a pixel that is not the last of its point");

endmodule

`default_nettype wire

// ===== sv/circle_rasterizer_top.sv =====
// Midpoint circle rasterizer with eight-way symmetry. A start or a step that
// still has a point to draw produces eight pixels, one per cycle at the pixel
// port while the port is ready; the single pixel output register sets that
// rate. A step with nothing to draw produces no pixels and pushes no job.
// Commands are taken one per cycle until the two-entry job queue is full, so
// the command side runs ahead of the pixel side by up to two points plus the
// one being emitted.
`default_nettype none

module circle_rasterizer_top #(
	parameter int COORD_BITS = 12
) (
	input  wire      clk,
	input  wire      arst_n,
	cr_cmd_if.sink   cmd,
	cr_pix_if.source pix
);
	localparam int JOB_W = 4 * COORD_BITS + 3;
	localparam int QUEUE_DEPTH = 2;

	logic             push_valid, push_ready, pop_valid, pop_ready;
	logic [JOB_W-1:0] push_data, pop_data;

	cr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	cr_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	cr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.pix(pix)
	);

endmodule

`default_nettype wire
